// ===== sv/decimal_wide_to_narrow_round_defines.svh =====
// Assertion macros for the wide-to-narrow decimal rounding block.
// Included inside module bodies; expects clk_i and rst_ni in scope.
`ifndef DECIMAL_WIDE_TO_NARROW_ROUND_DEFINES_SVH
`define DECIMAL_WIDE_TO_NARROW_ROUND_DEFINES_SVH
`ifndef SYNTHESIS
`define DWNR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dwnr assertion failed");
`define DWNR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dwnr assertion failed");
`else
`define DWNR_ASSERT(lbl, prop)
`define DWNR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== sv/dwnr_pkg.sv =====
// Types and constants for the wide-to-narrow decimal rounding block.
// No dependencies.
package dwnr_pkg;

  localparam int unsigned MANT_W      = 192;
  localparam int unsigned RES_W       = 96;
  localparam int unsigned LIMB_W      = 32;
  localparam int unsigned LIMBS       = MANT_W / LIMB_W;
  localparam int unsigned LIMB_CNT_W  = 3;
  localparam int unsigned REM_W       = 4;
  localparam int unsigned CUR_W       = LIMB_W + REM_W;
  localparam int unsigned PROD_W      = CUR_W + LIMB_W;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned MAX_SCALE   = 28;

  // floor(2^35 / 10)
  localparam logic [LIMB_W-1:0] RECIP       = 32'hCCCC_CCCC;
  localparam logic [REM_W-1:0]  ROUND_DIGIT = 4'd5;
  localparam logic [REM_W-1:0]  RADIX       = 4'd10;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_POS_OVF = 2'd1;
  localparam logic [1:0] STATUS_NEG_OVF = 2'd2;

  typedef struct packed {
    logic [63:0] mant_low;
    logic [63:0] mant_mid;
    logic [63:0] mant_high;
    logic [7:0]  in_scale;
    logic        in_sign;
  } dwnr_req_t;

  typedef struct packed {
    logic [63:0] res_low;
    logic [31:0] res_high;
    logic [4:0]  res_scale;
    logic        res_sign;
    logic [1:0]  status;
  } dwnr_rsp_t;

  typedef struct packed {
    logic [LIMB_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } dwnr_div_t;

endpackage

// ===== sv/dwnr_div10.sv =====
// One 32-bit limb step of a long division by ten.
// Depends on dwnr_pkg.
module dwnr_div10 (
  input  logic [dwnr_pkg::REM_W-1:0]  rem_i,
  input  logic [dwnr_pkg::LIMB_W-1:0] limb_i,
  output dwnr_pkg::dwnr_div_t         res_o
);
  import dwnr_pkg::*;

  logic [CUR_W-1:0]            cur;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-RECIP_SHIFT-1:0] q0;
  logic [CUR_W-1:0]            q0_ext;
  logic [CUR_W-1:0]            q10;
  logic [CUR_W-1:0]            r0;
  logic                        fix;

  // reciprocal estimate is low by at most one
  assign cur    = {rem_i, limb_i};
  assign prod   = PROD_W'(cur) * PROD_W'(RECIP);
  assign q0     = prod[PROD_W-1:RECIP_SHIFT];
  assign q0_ext = CUR_W'(q0);
  assign q10    = (q0_ext << 3) + (q0_ext << 1);
  assign r0     = cur - q10;
  assign fix    = r0[REM_W:0] >= {1'b0, RADIX};

  assign res_o.quot = fix ? (q0[LIMB_W-1:0] + LIMB_W'(1)) : q0[LIMB_W-1:0];
  assign res_o.rem  = fix ? (r0[REM_W-1:0] - RADIX) : r0[REM_W-1:0];

endmodule

// ===== sv/decimal_wide_to_narrow_round.sv =====
// Each request runs N divide-by-ten steps, then a round and a finish state
// (no round on underflow); N is at most 58 since the mantissa then hits zero.
// Each step is a check state, then the 192-bit mantissa walking one limb at
// a time through one shared limb divider, then a post (loop) state.
// One request at a time; a new one is taken the cycle after the result loads.
// rst_ni clears the sequencer and the result valid asynchronously.
module decimal_wide_to_narrow_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dwnr_pkg::dwnr_req_t  in_req_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output dwnr_pkg::dwnr_rsp_t  out_rsp_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);
  import dwnr_pkg::*;
  `include "decimal_wide_to_narrow_round_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_POST,
    ST_ROUND,
    ST_FIN
  } state_e;

  state_e                state_q;
  logic [LIMB_CNT_W-1:0] cnt_q;
  logic                  uflow_q;
  logic                  out_valid_q;
  logic [MANT_W-1:0]     mant_q;
  logic [7:0]            scale_q;
  logic                  sign_q;
  logic [REM_W-1:0]      rem_q;
  logic [REM_W-1:0]      drop_q;
  dwnr_rsp_t             rsp_q;

  dwnr_div_t div_res;
  dwnr_rsp_t fin_rsp;
  logic      upper_nz;
  logic      mant_nz;
  logic      scale_big;
  logic      keep_div;
  logic      last_limb;
  logic      out_free;
  logic      req_take;
  logic [1:0] fin_status;

  dwnr_div10 u_div (
    .rem_i  (rem_q),
    .limb_i (mant_q[MANT_W-1 -: LIMB_W]),
    .res_o  (div_res)
  );

  assign upper_nz  = |mant_q[MANT_W-1:RES_W];
  assign mant_nz   = |mant_q;
  assign scale_big = scale_q > 8'(MAX_SCALE);
  assign keep_div  = (upper_nz && (scale_q != 8'd0)) || scale_big;
  assign last_limb = cnt_q == LIMB_CNT_W'(LIMBS - 1);
  assign out_free  = !out_valid_q || out_ready_i;
  assign req_take  = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    if (uflow_q) begin
      fin_status = STATUS_NEG_OVF;
    end else if (upper_nz) begin
      fin_status = sign_q ? STATUS_NEG_OVF : STATUS_POS_OVF;
    end else begin
      fin_status = STATUS_OK;
    end
    fin_rsp = '0;
    fin_rsp.status = fin_status;
    if (fin_status == STATUS_OK) begin
      fin_rsp.res_low   = mant_q[63:0];
      fin_rsp.res_high  = mant_q[RES_W-1:64];
      fin_rsp.res_scale = scale_q[4:0];
      fin_rsp.res_sign  = sign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      uflow_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            uflow_q <= 1'b0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt_q   <= '0;
          state_q <= keep_div ? ST_DIV : ST_ROUND;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + LIMB_CNT_W'(1);
          if (last_limb) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          if (scale_big && !mant_nz) begin
            uflow_q <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_ROUND: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      mant_q  <= {in_req_i.mant_high, in_req_i.mant_mid, in_req_i.mant_low};
      scale_q <= in_req_i.in_scale;
      sign_q  <= in_req_i.in_sign;
      drop_q  <= '0;
    end
    if (state_q == ST_CHECK) begin
      rem_q <= '0;
    end
    if (state_q == ST_DIV) begin
      mant_q <= {mant_q[MANT_W-LIMB_W-1:0], div_res.quot};
      rem_q  <= div_res.rem;
      if (last_limb) begin
        scale_q <= scale_q - 8'd1;
        drop_q  <= div_res.rem;
      end
    end
    if ((state_q == ST_ROUND) && (drop_q >= ROUND_DIGIT)) begin
      mant_q <= mant_q + MANT_W'(1);
    end
    if ((state_q == ST_FIN) && out_free) begin
      rsp_q <= fin_rsp;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `DWNR_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  `DWNR_ASSERT(a_rem_digit, (state_q == ST_DIV) |-> (rem_q < RADIX))
  `DWNR_ASSERT_NEXT(a_scale_step, (state_q == ST_DIV) && last_limb, scale_q == $past(scale_q) - 8'd1)
  `DWNR_ASSERT(a_round_scale, (state_q == ST_ROUND) |-> (scale_q <= 8'(MAX_SCALE)))
  `DWNR_ASSERT(a_err_zero, (out_valid_o && (out_rsp_o.status != STATUS_OK)) |-> ((out_rsp_o.res_low == '0) && (out_rsp_o.res_high == '0) && (out_rsp_o.res_scale == '0) && !out_rsp_o.res_sign))

endmodule

// ===== test/decimal_round_checker.sv =====
`timescale 1ns / 1ps
// Checker for decimal_wide_to_narrow_round: watches both channels, predicts each
// narrowed and rounded result, and compares it field by field. Needs dwnr_pkg.
module decimal_round_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dwnr_pkg::dwnr_req_t in_req_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dwnr_pkg::dwnr_rsp_t out_rsp_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import dwnr_pkg::*;

  dwnr_rsp_t   rounded_q[$];
  int unsigned fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // divide by ten until the scale is legal and the value fits or the scale is zero; round on the last digit
  function automatic dwnr_rsp_t narrow_and_round(input dwnr_req_t req);
    logic [MANT_W-1:0] mant;
    int unsigned       scale;
    logic [REM_W-1:0]  dropped;
    logic [1:0]        status;
    dwnr_rsp_t         rsp;
    mant = {req.mant_high, req.mant_mid, req.mant_low};
    scale = req.in_scale;
    dropped = '0;
    status = STATUS_OK;
    while (status == STATUS_OK &&
           ((mant[MANT_W-1:RES_W] != '0 && scale > 0) || scale > MAX_SCALE)) begin
      dropped = REM_W'(mant % RADIX);
      mant = mant / RADIX;
      scale = scale - 1;
      // underflow shares the negative status code
      if (scale > MAX_SCALE && mant == '0) status = STATUS_NEG_OVF;
    end
    if (status == STATUS_OK) begin
      if (dropped >= ROUND_DIGIT) mant = mant + 1'b1;
      if (mant[MANT_W-1:RES_W] != '0) status = req.in_sign ? STATUS_NEG_OVF : STATUS_POS_OVF;
    end
    rsp = '0;
    rsp.status = status;
    if (status == STATUS_OK) begin
      rsp.res_low   = mant[63:0];
      rsp.res_high  = mant[95:64];
      rsp.res_scale = scale[4:0];
      rsp.res_sign  = req.in_sign;
    end
    return rsp;
  endfunction

  always @(posedge clk_i) begin : watch
    dwnr_rsp_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (rounded_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_rsp_i);
          fails++;
        end else begin
          want = rounded_q.pop_front();
          if (out_rsp_i.res_low != want.res_low) begin
            $error("res_low: expected %h, got %h", want.res_low, out_rsp_i.res_low);
            fails++;
          end
          if (out_rsp_i.res_high != want.res_high) begin
            $error("res_high: expected %h, got %h", want.res_high, out_rsp_i.res_high);
            fails++;
          end
          if (out_rsp_i.res_scale != want.res_scale) begin
            $error("res_scale: expected %0d, got %0d", want.res_scale, out_rsp_i.res_scale);
            fails++;
          end
          if (out_rsp_i.res_sign != want.res_sign) begin
            $error("res_sign: expected %0d, got %0d", want.res_sign, out_rsp_i.res_sign);
            fails++;
          end
          if (out_rsp_i.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_i.status);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) rounded_q.push_back(narrow_and_round(in_req_i));
    end
    fail_count_o <= fails;
    pending_o <= rounded_q.size();
  end

endmodule

// ===== test/tb_decimal_wide_to_narrow_round.sv =====
`timescale 1ns / 1ps
// Testbench top for decimal_wide_to_narrow_round: drives requests and result
// backpressure, and gives the verdict. Needs dwnr_pkg and decimal_round_checker.
module tb_decimal_wide_to_narrow_round;
  import dwnr_pkg::*;

  localparam logic [MANT_W-1:0] NARROW_MAX = (192'd1 << RES_W) - 1;
  localparam int unsigned       N_RANDOM   = 1280;
  localparam int unsigned       DRAIN_MAX  = 4000;

  logic        clk;
  logic        rst_n = 1'b0;
  dwnr_req_t   in_req = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  dwnr_rsp_t   out_rsp;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bit          steady = 1'b0;
  int unsigned ready_left = 0;
  int unsigned fail_count;
  int unsigned pending;

  decimal_wide_to_narrow_round u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_req_i    (in_req),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_rsp_o   (out_rsp),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  decimal_round_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_req_i     (in_req),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .out_rsp_i    (out_rsp),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] rand_limb();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [MANT_W-1:0] ten_to(input int unsigned k);
    logic [MANT_W-1:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic dwnr_req_t make_req(input logic [MANT_W-1:0] mant,
                                         input logic [7:0] scale, input logic sign);
    dwnr_req_t req;
    {req.mant_high, req.mant_mid, req.mant_low} = mant;
    req.in_scale = scale;
    req.in_sign  = sign;
    return req;
  endfunction

  task automatic send_request(input dwnr_req_t req);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b0;
      ready_left <= pick_gap();
    end
  end

  // random request: wide values, values that narrow close to the 96-bit edge, and small ones
  function automatic dwnr_req_t random_req();
    logic [MANT_W-1:0] mant;
    logic [RES_W-1:0]  base;
    logic [63:0]       lo;
    logic [63:0]       hi;
    int unsigned       k;
    int unsigned       scale;
    int unsigned       kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      mant = {rand_limb(), rand_limb(), rand_limb()};
      scale = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 255);
    end else if (kind <= 6) begin
      k = $urandom_range(0, MAX_SCALE);
      lo = rand_limb();
      hi = rand_limb();
      base = {hi[31:0], lo};
      if ($urandom_range(0, 3) == 0) base = '1 - $urandom_range(0, 3);
      mant = base * ten_to(k) + ({$urandom, $urandom, $urandom, $urandom} % ten_to(k));
      scale = k + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0);
    end else if (kind <= 8) begin
      mant = {128'b0, rand_limb()} >> $urandom_range(0, 63);
      scale = $urandom_range(20, 70);
    end else begin
      mant = $urandom_range(0, 20);
      scale = $urandom_range(0, 255);
    end
    return make_req(mant, scale[7:0], $urandom_range(0, 1));
  endfunction

  initial begin : stimulus
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_request(make_req(0, 0, 0));
    send_request(make_req(0, 0, 1));
    send_request(make_req(NARROW_MAX, 28, 0));
    send_request(make_req(NARROW_MAX, 0, 1));
    send_request(make_req(NARROW_MAX + 1, 0, 0));
    send_request(make_req(NARROW_MAX + 1, 0, 1));
    send_request(make_req('1, 255, 0));
    send_request(make_req('1, 28, 1));
    send_request(make_req('1, 28, 0));
    send_request(make_req(0, 29, 1));
    send_request(make_req(0, 30, 0));
    send_request(make_req(5, 29, 0));
    send_request(make_req(4, 29, 1));
    send_request(make_req(1, 30, 1));
    send_request(make_req(NARROW_MAX * 10 + 5, 1, 0));
    send_request(make_req(NARROW_MAX * 10 + 5, 1, 1));
    send_request(make_req((NARROW_MAX - 1) * 10 + 9, 5, 0));
    send_request(make_req(NARROW_MAX * 10 + 4, 1, 1));
    send_request(make_req(192'd1 << 191, 3, 0));
    send_request(make_req({64'hFFFF_FFFF_FFFF_FFFF, 128'b0}, 28, 1));
    send_request(make_req({64'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'b0}, 255, 0));
    send_request(make_req(ten_to(57), 255, 0));
    send_request(make_req({3{64'h5555_5555_5555_5555}}, 8'h55, 1));
    send_request(make_req({3{64'hAAAA_AAAA_AAAA_AAAA}}, 8'hAA, 0));

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      steady = (i % 250) >= 200;
      send_request(random_req());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_MAX);
    repeat (32) @(posedge clk);

    if (pending != 0) $error("%0d requests never answered", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== decimal_wide_to_narrow_round.f =====
+incdir+sv
sv/dwnr_pkg.sv
sv/dwnr_div10.sv
sv/decimal_wide_to_narrow_round.sv
test/decimal_round_checker.sv
test/tb_decimal_wide_to_narrow_round.sv
